>>> src/vbv_pkg.sv
// Package for the version-bit vote deployment tracker.
// Beat payload structs, configuration struct, register indexes and state codes.
// No dependencies.
package vbv_pkg;

  // deployment state codes
  localparam logic [2:0] StDefined = 3'd0;
  localparam logic [2:0] StStarted = 3'd1;
  localparam logic [2:0] StLocked  = 3'd2;
  localparam logic [2:0] StActive  = 3'd3;
  localparam logic [2:0] StFailed  = 3'd4;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 33;
  localparam logic [CfgIdxW-1:0] CfgStartTime   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTime = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPeriodLen   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgVoteThresh  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSignalBit   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgForkTime    = 3'd5;

  // top-bits pattern required before the fork time
  localparam logic [2:0] TopBits = 3'b001;

  // start time value meaning always active
  localparam logic signed [32:0] StartAlways = -33'sd1;

  typedef struct packed {
    logic [31:0] block_version;
    logic [31:0] block_time;
    logic [31:0] median_time;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  next_state;
    logic [31:0] since_height;
    logic        did_signal;
    logic [15:0] window_elapsed;
    logic [15:0] window_count;
    logic        still_possible;
  } out_beat_t;

  typedef struct packed {
    logic signed [32:0] start_mtp;
    logic [31:0]        timeout_time;
    logic [15:0]        period_length;
    logic [15:0]        vote_threshold;
    logic [4:0]         signal_bit;
    logic [31:0]        fork_time;
  } cfg_t;

endpackage

>>> src/vbv_sig_det.sv
// Signalling detector: tests one block's version word for the deployment bit.
// Depends on vbv_pkg.
module vbv_sig_det (
  input  logic [31:0] version_i,
  input  logic [31:0] time_i,
  input  logic [4:0]  signal_bit_i,
  input  logic [31:0] fork_time_i,
  output logic        signal_o
);
  import vbv_pkg::*;

  logic bit_set;
  logic top_ok;

  // deployment bit, plus top-bits pattern until the fork time has passed
  assign bit_set  = version_i[signal_bit_i];
  assign top_ok   = (version_i[31:29] == TopBits);
  assign signal_o = (time_i > fork_time_i) ? bit_set : (bit_set && top_ok);

endmodule

>>> src/vbv_tracker.sv
// Running window counters, height and deployment state machine.
// Computes one result beat per block and updates state when the block advances.
// Depends on vbv_pkg.
module vbv_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  vbv_pkg::cfg_t      cfg_i,
  input  logic [31:0]        median_time_i,
  input  logic               signal_i,
  output vbv_pkg::out_beat_t result_o
);
  import vbv_pkg::*;

  logic [15:0] phase_q, phase_d;
  logic [15:0] count_q, count_d;
  logic [31:0] height_q, height_d;
  logic [2:0]  state_q, state_d;
  logic [31:0] since_q, since_d;

  logic [15:0] per;
  logic [16:0] phase_inc;
  logic [16:0] cnt;
  logic        win_end;
  logic        before_start;
  logic        timed_out;
  logic [2:0]  ns;
  logic [17:0] lhs, rhs;

  // effective period, zero acts as one
  assign per       = (cfg_i.period_length == '0) ? 16'd1 : cfg_i.period_length;
  assign phase_inc = {1'b0, phase_q} + 17'd1;
  assign cnt       = {1'b0, count_q} + {16'd0, signal_i};
  assign win_end   = (phase_inc >= {1'b0, per});

  assign before_start = ($signed({1'b0, median_time_i}) < cfg_i.start_mtp);
  assign timed_out    = (median_time_i >= cfg_i.timeout_time);

  // transition at window end
  always_comb begin
    ns = state_q;
    if (before_start) begin
      ns = StDefined;
    end else begin
      unique case (state_q)
        StDefined: ns = timed_out ? StFailed : StStarted;
        StStarted: begin
          if (timed_out) begin
            ns = StFailed;
          end else if (cnt >= {1'b0, cfg_i.vote_threshold}) begin
            ns = StLocked;
          end
        end
        StLocked: ns = StActive;
        default:  ns = state_q;
      endcase
    end
  end

  // next values of the running state
  always_comb begin
    height_d = (height_q == '1) ? height_q : height_q + 32'd1;
    state_d  = state_q;
    since_d  = since_q;
    if (win_end) begin
      phase_d = '0;
      count_d = '0;
      state_d = ns;
      if (ns != state_q) begin
        since_d = height_d;
      end
    end else begin
      phase_d = phase_inc[15:0];
      count_d = cnt[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      count_q  <= '0;
      height_q <= '0;
      state_q  <= StDefined;
      since_q  <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      height_q <= height_d;
      state_q  <= state_d;
      since_q  <= since_d;
    end
  end

  // threshold still reachable: per + count >= threshold + elapsed
  assign lhs = {2'b00, per} + {2'b00, count_d};
  assign rhs = {2'b00, cfg_i.vote_threshold} + {2'b00, phase_d};

  // reported beat
  always_comb begin
    result_o.did_signal     = signal_i;
    result_o.window_elapsed = phase_d;
    result_o.window_count   = count_d;
    result_o.still_possible = (lhs >= rhs);
    if (cfg_i.start_mtp == StartAlways) begin
      result_o.next_state   = StActive;
      result_o.since_height = '0;
    end else begin
      result_o.next_state   = state_d;
      result_o.since_height = (state_d == StDefined) ? 32'd0 : since_d;
    end
  end

endmodule

>>> src/version_bit_vote_deployment_tracker_top.sv
// Version-bit vote deployment tracker, top level.
// Path: an accepted block beat is held in the input register, then its result beat in the result register.
// Throughput: one block per cycle while results are taken; a stalled result holds the input register.
// Reset: asynchronous active low; clears window counters, height and deployment state,
// and loads the configuration registers with their defaults.
// Depends on vbv_pkg, vbv_sig_det and vbv_tracker.
module version_bit_vote_deployment_tracker_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  vbv_pkg::in_beat_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output vbv_pkg::out_beat_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [vbv_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [vbv_pkg::CfgDataW-1:0]    cfg_data_i
);
  import vbv_pkg::*;

  cfg_t      cfg_q;
  logic      a_valid_q, a_valid_d;
  in_beat_t  a_data_q;
  logic      o_valid_q, o_valid_d;
  out_beat_t o_data_q;
  logic      a_adv;
  logic      in_fire;
  logic      sig;
  out_beat_t result;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_mtp      <= 33'sh0_FFFF_FFFF;
      cfg_q.timeout_time   <= 32'hFFFF_FFFF;
      cfg_q.period_length  <= 16'd2016;
      cfg_q.vote_threshold <= 16'd1916;
      cfg_q.signal_bit     <= 5'd0;
      cfg_q.fork_time      <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgStartTime:   cfg_q.start_mtp      <= $signed(cfg_data_i);
        CfgTimeoutTime: cfg_q.timeout_time   <= cfg_data_i[31:0];
        CfgPeriodLen:   cfg_q.period_length  <= cfg_data_i[15:0];
        CfgVoteThresh:  cfg_q.vote_threshold <= cfg_data_i[15:0];
        CfgSignalBit:   cfg_q.signal_bit     <= cfg_data_i[4:0];
        CfgForkTime:    cfg_q.fork_time      <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign a_adv      = a_valid_q && (!o_valid_q || out_ready_i);
  assign in_ready_o = !a_valid_q || a_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_fire) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
    o_valid_d = o_valid_q;
    if (a_adv) begin
      o_valid_d = 1'b1;
    end else if (out_ready_i) begin
      o_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      o_valid_q <= o_valid_d;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_data_q <= in_data_i;
    end
  end

  vbv_sig_det u_sig_det (
    .version_i    (a_data_q.block_version),
    .time_i       (a_data_q.block_time),
    .signal_bit_i (cfg_q.signal_bit),
    .fork_time_i  (cfg_q.fork_time),
    .signal_o     (sig)
  );

  vbv_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (a_adv),
    .cfg_i         (cfg_q),
    .median_time_i (a_data_q.median_time),
    .signal_i      (sig),
    .result_o      (result)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      o_data_q <= result;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

>>> src/vbv_checker.sv
// Port-level checks for the deployment tracker, bound to the top level.
// Depends on vbv_pkg.
module vbv_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input vbv_pkg::out_beat_t           out_data_o
);
  import vbv_pkg::*;

  // stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed under stall");

  // signalling count never exceeds elapsed blocks of the window
  a_count_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.window_count <= out_data_o.window_elapsed)
    else $error("window count above elapsed blocks");

  // defined state reports since height zero
  a_defined_since: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.next_state == StDefined |-> out_data_o.since_height == '0)
    else $error("defined state with nonzero since height");

  // an accepted block beat shows up as a result, through the input and result registers, when unstalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result beat missing after accepted block");

endmodule

bind version_bit_vote_deployment_tracker_top vbv_checker u_vbv_checker (.*);
